FILE: hw/rtl/pmm_pkg.sv
// ----------------------------------------------------------------------------
// Pattern matcher package
// Shared constants, register indexes and types of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package pmm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int PAT_BYTES       = 32;
    localparam int PAT_REGS        = 4;
    localparam int LEN_REG_W       = 6;
    localparam int CFG_ADDR_W      = 6;
    localparam int CFG_DATA_W      = 64;
    localparam int REG_SEL_W       = 3;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h2E;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    localparam logic [REG_SEL_W-1:0] REG_LEN  = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_PAT0 = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_PAT1 = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_PAT2 = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_PAT3 = 3'd4;

    typedef struct packed {
        logic skip;
        logic step;
    } pmm_link_t;

    typedef struct packed {
        logic full;
        logic any;
    } pmm_result_t;

endpackage

FILE: hw/rtl/wildcard_star_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Streams text bytes against a pattern with '.' and 'x*' elements.
// ----------------------------------------------------------------------------
// Input beats carry operation and text_byte; a beat is taken when in_valid is
// high and in_stall is low. Operation zero starts a new empty text, operation
// one appends text_byte. Each input beat yields one output beat with
// full_match and still_possible, taken when out_valid is high and out_stall is
// low.
// The user must write the pattern and its length through the APB port only
// while no beat is in flight; the block itself does not enforce this.
// A row of cells, one per pattern position, updates the active positions on
// each beat; the skip closure ripples along the row from each cell to the
// cell two places on. One beat is taken per cycle while in_stall is low. A
// result is formed from the registered active positions and is then
// registered in the output buffer.
// A two-entry output buffer lets input beats keep arriving while a result
// waits; in_stall rises only when the buffer would overflow.
// Reset clears the pattern registers, leaves position zero active and empties
// the output buffer.
// ----------------------------------------------------------------------------
module wildcard_star_pattern_matcher_top #(
    parameter int PATTERN_MAX = pmm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [7:0]                      text_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            full_match,
    output logic                            still_possible,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pmm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pmm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import pmm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_REG_W-1:0]  len_reg;
    logic [CFG_DATA_W-1:0] pat_reg [PAT_REGS];
    logic [REG_SEL_W-1:0]  reg_sel;
    logic                  cfg_write;
    logic [PAT_REGS*CFG_DATA_W-1:0] pat_flat;

    logic [LEN_W-1:0]  len_eff;
    logic [7:0]        pbyte [PATTERN_MAX + 2];
    pmm_link_t         link [PATTERN_MAX + 1];
    logic [PATTERN_MAX:0] closed;

    logic        accept;
    logic        start;
    logic        advance;
    logic        rep_valid_reg;
    pmm_result_t rep;

    pmm_result_t head_reg;
    pmm_result_t head_next;
    pmm_result_t skid_reg;
    pmm_result_t skid_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;
    logic [2:0]  load;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[CFG_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < PAT_REGS; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_LEN:  len_reg    <= pwdata[LEN_REG_W-1:0];
                REG_PAT0: pat_reg[0] <= pwdata;
                REG_PAT1: pat_reg[1] <= pwdata;
                REG_PAT2: pat_reg[2] <= pwdata;
                REG_PAT3: pat_reg[3] <= pwdata;
                default:  len_reg    <= len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LEN:  prdata = {{(CFG_DATA_W - LEN_REG_W){1'b0}}, len_reg};
            REG_PAT0: prdata = pat_reg[0];
            REG_PAT1: prdata = pat_reg[1];
            REG_PAT2: prdata = pat_reg[2];
            REG_PAT3: prdata = pat_reg[3];
            default:  prdata = '0;
        endcase
    end

    assign pat_flat = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
    assign len_eff  = (int'(len_reg) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_reg);

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX + 2; k++)
        begin : g_byte
            if (k < PAT_BYTES)
            begin : g_reg
                assign pbyte[k] = pat_flat[8*k +: 8];
            end
            else
            begin : g_zero
                assign pbyte[k] = 8'h00;
            end
        end
    endgenerate

    assign accept  = in_valid && !in_stall;
    assign start   = accept && (operation == OP_START);
    assign advance = accept && (operation == OP_APPEND);

    genvar j;
    generate
        for (j = 0; j <= PATTERN_MAX; j++)
        begin : g_cell
            pmm_link_t prev1;
            pmm_link_t prev2;
            if (j >= 1)
            begin : g_p1
                assign prev1 = link[j-1];
            end
            else
            begin : g_n1
                assign prev1 = '0;
            end
            if (j >= 2)
            begin : g_p2
                assign prev2 = link[j-2];
            end
            else
            begin : g_n2
                assign prev2 = '0;
            end

            pmm_cell #(
                .PATTERN_MAX (PATTERN_MAX),
                .INDEX       (j),
                .LEN_W       (LEN_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .start     (start),
                .advance   (advance),
                .len       (len_eff),
                .own_byte  (pbyte[j]),
                .next_byte (pbyte[j+1]),
                .text_byte (text_byte),
                .prev1     (prev1),
                .prev2     (prev2),
                .link_out  (link[j]),
                .closed    (closed[j])
            );
        end
    endgenerate

    assign rep.full = closed[len_eff];
    assign rep.any  = |closed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_valid_reg <= 1'b0;
        end
        else
        begin
            rep_valid_reg <= accept;
        end
    end

    assign out_valid      = (count_reg != 2'd0);
    assign pop            = out_valid && !out_stall;
    assign full_match     = head_reg.full;
    assign still_possible = head_reg.any;

    assign load     = {1'b0, count_reg} + {2'b00, rep_valid_reg};
    assign in_stall = load > ({2'b00, pop} + 3'd1);

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        if (rep_valid_reg && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = rep;
            end
            else
            begin
                skid_next = rep;
            end
            count_next = count_reg + 2'd1;
        end
        else if (rep_valid_reg && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = rep;
            end
            else
            begin
                head_next = skid_reg;
                skid_next = rep;
            end
        end
        else if (pop)
        begin
            head_next  = skid_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: hw/rtl/pmm_cell.sv
// ----------------------------------------------------------------------------
// Pattern matcher cell
// Holds one active pattern position and forms its closure and next value.
// ----------------------------------------------------------------------------
module pmm_cell #(
    parameter int PATTERN_MAX = pmm_pkg::PATTERN_MAX_DEF,
    parameter int INDEX       = 0,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               advance,
    input  logic [LEN_W-1:0]   len,
    input  logic [7:0]         own_byte,
    input  logic [7:0]         next_byte,
    input  logic [7:0]         text_byte,
    input  pmm_pkg::pmm_link_t prev1,
    input  pmm_pkg::pmm_link_t prev2,
    output pmm_pkg::pmm_link_t link_out,
    output logic               closed
);
    import pmm_pkg::*;

    localparam logic RESET_ACTIVE = (INDEX == 0);

    logic active_reg;
    logic active_next;
    logic in_range;
    logic below_len;
    logic starred;
    logic hit;

    assign in_range  = (LEN_W + 1)'(INDEX) <= {1'b0, len};
    assign below_len = (LEN_W + 1)'(INDEX) < {1'b0, len};
    assign starred   = ((LEN_W + 1)'(INDEX + 1) < {1'b0, len}) && (next_byte == STAR_BYTE);
    assign hit       = (own_byte == ANY_BYTE) || (own_byte == text_byte);

    assign closed        = (active_reg && in_range) || prev2.skip;
    assign link_out.skip = closed && starred;
    assign link_out.step = closed && hit && below_len && !starred;

    always_comb
    begin
        active_next = active_reg;
        if (start)
        begin
            active_next = RESET_ACTIVE;
        end
        else if (advance)
        begin
            active_next = prev1.step || (closed && hit && below_len && starred);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= RESET_ACTIVE;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

FILE: hw/rtl/pmm_checker.sv
// ----------------------------------------------------------------------------
// Pattern matcher checker
// Port-level assertions on the wildcard pattern matcher, bound to its top.
// ----------------------------------------------------------------------------
module pmm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic full_match,
    input logic still_possible
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(full_match) && $stable(still_possible))
        else $error("output beat changed while stalled");

    a_full_implies_possible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !full_match || still_possible)
        else $error("full match reported with no active position");

    a_stall_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind wildcard_star_pattern_matcher_top pmm_checker u_pmm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .full_match     (full_match),
    .still_possible (still_possible)
);
